@@ design/stack_bytecode_execution_unit_defines.svh @@
// assertion helpers for the execution unit
`ifndef STACK_BYTECODE_EXECUTION_UNIT_DEFINES_SVH
`define STACK_BYTECODE_EXECUTION_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SBX_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define SBX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");

`endif

@@ design/sbx_pkg.sv @@
`default_nettype none
package sbx_pkg;
  localparam int unsigned StackDepth = 256;
  localparam int unsigned LocalCount = 256;
  localparam int unsigned PoolDepth  = 1024;
  localparam int unsigned SpW = $clog2(StackDepth);
  localparam int unsigned DepW = $clog2(StackDepth) + 1;
  localparam int unsigned LocW = $clog2(LocalCount);
  localparam int unsigned PoolW = $clog2(PoolDepth);

  localparam logic [7:0] OpIconstM1 = 8'h02;
  localparam logic [7:0] OpIconst5 = 8'h08;
  localparam logic [7:0] OpIload0 = 8'h1a;
  localparam logic [7:0] OpIload3 = 8'h1d;
  localparam logic [7:0] OpIstore0 = 8'h3b;
  localparam logic [7:0] OpIstore3 = 8'h3e;
  localparam logic [7:0] OpBipush = 8'h10;
  localparam logic [7:0] OpSipush = 8'h11;
  localparam logic [7:0] OpLdc = 8'h12;
  localparam logic [7:0] OpLdcW = 8'h13;
  localparam logic [7:0] OpIload = 8'h15;
  localparam logic [7:0] OpIstore = 8'h36;
  localparam logic [7:0] OpDup = 8'h59;
  localparam logic [7:0] OpIadd = 8'h60;
  localparam logic [7:0] OpIsub = 8'h64;
  localparam logic [7:0] OpImul = 8'h68;
  localparam logic [7:0] OpIdiv = 8'h6c;
  localparam logic [7:0] OpIneg = 8'h74;
  localparam logic [7:0] OpGetstatic = 8'hb2;
  localparam logic [7:0] OpInvoke = 8'hb6;
  localparam logic [7:0] OpReturn = 8'hb1;

  localparam logic [1:0] VkNone = 2'd0;
  localparam logic [1:0] VkInt = 2'd1;
  localparam logic [1:0] VkStr = 2'd2;
  localparam logic [1:0] VkStream = 2'd3;

  // constant pool entry kinds
  localparam logic [3:0] PkUnusable = 4'd0;
  localparam logic [3:0] PkInt = 4'd1;
  localparam logic [3:0] PkStr = 4'd2;
  localparam logic [3:0] PkStdout = 4'd3;
  localparam logic [3:0] PkPrintlnStr = 4'd4;
  localparam logic [3:0] PkPrintlnInt = 4'd5;
  localparam logic [3:0] PkPrintlnAny = 4'd6;
  localparam logic [3:0] PkPrintStr = 4'd7;
  localparam logic [3:0] PkPrintInt = 4'd8;
  localparam logic [3:0] PkPrintAny = 4'd9;
  localparam logic [3:0] PkMethod = 4'd10;

  localparam logic [2:0] EvNone = 3'd0;
  localparam logic [2:0] EvPint = 3'd1;
  localparam logic [2:0] EvPstr = 3'd2;
  localparam logic [2:0] EvDone = 3'd3;
  localparam logic [2:0] EvErr = 3'd4;
  localparam logic [2:0] EvHalted = 3'd5;

  localparam logic [3:0] ErrNone = 4'd0;
  localparam logic [3:0] ErrOpcode = 4'd1;
  localparam logic [3:0] ErrConst = 4'd2;
  localparam logic [3:0] ErrDivZero = 4'd3;
  localparam logic [3:0] ErrGetstatic = 4'd4;
  localparam logic [3:0] ErrInvoke = 4'd5;
  localparam logic [3:0] ErrSig = 4'd6;
  localparam logic [3:0] ErrMethod = 4'd7;
  localparam logic [3:0] ErrStack = 4'd8;

  typedef struct packed {
    logic [2:0]  ev;
    logic        nl;
    logic [31:0] val;
    logic [3:0]  err;
  } result_t;
endpackage
`default_nettype wire

@@ design/stack_bytecode_execution_unit.sv @@
`default_nettype none
// Stack bytecode execution unit.
// s_axis: one beat per item. tuser = func. tdata bits from low up: opcode[7:0],
// operand[15:0], entry_index[9:0], entry_kind[3:0], entry_value[31:0], 2 zero bits.
// m_axis: one beat per item. tdata from low up: event_res[2:0], newline,
// print_value[31:0], error_code[3:0].
// cfg_we_i/cfg_wdata_i write pool_entry_count; only while idle.
// One item is in flight at a time. The result is valid in the cycle after the accept
// edge for a load or for an execute item taken while halted; any other execute item
// passes through the read, execute and output states (fetch stack/locals/pool from the
// synchronous memories, compute, write back), and idiv also waits in the divide state
// for the bit-serial divider. A new beat is taken only back in idle.
// The result sits in an output register; a new item is taken once that beat
// leaves, so a stalled receiver holds the block.
// Reset clears depth, halt flag and the pool entry count at once, then a clearing
// pass zeroes the local slots; no item is taken during it.
module stack_bytecode_execution_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // opcode, operand, entry_index, kind, value
  input  wire logic        s_axis_tuser,  // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // event_res, newline, print_value, error_code
);
  import sbx_pkg::*;
  `include "stack_bytecode_execution_unit_defines.svh"

  localparam logic [2:0] StClr = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StExec = 3'd3;
  localparam logic [2:0] StDiv = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  logic [2:0] st_q, st_d;
  logic [DepW-1:0] dep_q, dep_d;
  logic stop_q, stop_d;
  logic [10:0] cnt_q;
  logic [LocW:0] clr_q;
  logic [7:0] op_q;
  logic [15:0] opnd_q;
  result_t res_q, res_d;

  logic [33:0] stk_mem [StackDepth];
  logic [33:0] loc_mem [LocalCount];
  logic [35:0] pool_mem [PoolDepth];
  logic [33:0] top_r, sec_r, loc_r;
  logic [35:0] pool_r;

  // memory controls
  logic stk_we, loc_we, pool_we;
  logic [SpW-1:0] stk_wa;
  logic [33:0] stk_wd, loc_wd;
  logic [LocW-1:0] loc_wa;
  logic [PoolW-1:0] pool_wa;
  logic [35:0] pool_wd;

  logic div_start, div_done;
  logic [31:0] div_q;

  sbx_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .dividend_i(sec_r[31:0]), .divisor_i(top_r[31:0]),
    .done_o(div_done), .quot_o(div_q)
  );

  logic acc;
  assign s_axis_tready = (st_q == StIdle);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata = {res_q.err, res_q.val, res_q.nl, res_q.ev};

  // read addresses taken at accept from the input beat
  logic [7:0] in_op;
  logic [15:0] in_opnd;
  logic [LocW-1:0] in_loc;
  logic [15:0] in_pidx;
  assign in_op = s_axis_tdata[7:0];
  assign in_opnd = s_axis_tdata[23:8];
  always_comb begin
    in_loc = '0;
    if (in_op == OpIload || in_op == OpIstore) in_loc = in_opnd[LocW-1:0];
    else if (in_op >= OpIload0 && in_op <= OpIload3) in_loc = LocW'(in_op - OpIload0);
    else in_loc = LocW'(in_op - OpIstore0);
    in_pidx = (in_op == OpLdc) ? {8'd0, in_opnd[7:0]} : in_opnd;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      top_r <= stk_mem[SpW'(dep_q - DepW'(1))];
      sec_r <= stk_mem[SpW'(dep_q - DepW'(2))];
      loc_r <= loc_mem[in_loc];
      pool_r <= pool_mem[in_pidx[PoolW-1:0]];
    end
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (loc_we) loc_mem[loc_wa] <= loc_wd;
    if (pool_we) pool_mem[pool_wa] <= pool_wd;
  end

  // pool lookup
  logic [15:0] pidx;
  logic [3:0] pk;
  logic [LocW:0] lidx;
  assign pidx = (op_q == OpLdc) ? {8'd0, opnd_q[7:0]} : opnd_q;
  always_comb begin
    if (pidx == 16'd0 || {5'd0, pidx} >= {10'd0, cnt_q} || {5'd0, pidx} >= 21'(PoolDepth))
      pk = PkUnusable;
    else pk = pool_r[35:32];
  end
  always_comb begin
    if (op_q == OpIload || op_q == OpIstore) lidx = (LocW+1)'(opnd_q[7:0]);
    else if (op_q >= OpIload0 && op_q <= OpIload3) lidx = (LocW+1)'(op_q - OpIload0);
    else lidx = (LocW+1)'(op_q - OpIstore0);
  end

  logic [31:0] mul_p;
  assign mul_p = sec_r[31:0] * top_r[31:0];

  always_comb begin
    logic do_push, is_load, is_store;
    logic [33:0] pv;
    logic [3:0] sk;
    st_d = st_q;
    dep_d = dep_q;
    stop_d = stop_q;
    res_d = res_q;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
    loc_we = 1'b0; loc_wa = '0; loc_wd = '0;
    pool_we = 1'b0; pool_wa = '0; pool_wd = '0;
    div_start = 1'b0;
    do_push = 1'b0;
    pv = '0;
    sk = ErrNone;
    is_load = (op_q == OpIload) || (op_q >= OpIload0 && op_q <= OpIload3);
    is_store = (op_q == OpIstore) || (op_q >= OpIstore0 && op_q <= OpIstore3);
    case (st_q)
      StClr: begin
        loc_we = 1'b1;
        loc_wa = clr_q[LocW-1:0];
        if (clr_q == (LocW+1)'(LocalCount - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (acc) begin
          res_d = '{ev: EvNone, nl: 1'b0, val: '0, err: ErrNone};
          if (!s_axis_tuser) begin
            pool_we = 1'b1;
            pool_wa = s_axis_tdata[33:24];
            pool_wd = {s_axis_tdata[37:34], s_axis_tdata[69:38]};
            st_d = StOut;
          end else if (stop_q) begin
            res_d.ev = EvHalted;
            st_d = StOut;
          end else st_d = StRead;
        end
      end
      StRead: st_d = StExec;
      StExec: begin
        st_d = StOut;
        if (op_q >= OpIconstM1 && op_q <= OpIconst5) begin
          do_push = 1'b1; pv = {VkInt, 32'(op_q) - 32'd3};
        end else if (is_load) begin
          if (lidx >= (LocW+1)'(LocalCount)) sk = ErrStack;
          else begin do_push = 1'b1; pv = loc_r; end
        end else if (is_store) begin
          if (lidx >= (LocW+1)'(LocalCount) || dep_q == '0) sk = ErrStack;
          else begin
            dep_d = dep_q - DepW'(1);
            loc_we = 1'b1; loc_wa = lidx[LocW-1:0]; loc_wd = top_r;
          end
        end else begin
          case (op_q)
            OpBipush: begin do_push = 1'b1; pv = {VkInt, {{24{opnd_q[7]}}, opnd_q[7:0]}}; end
            OpSipush: begin do_push = 1'b1; pv = {VkInt, {{16{opnd_q[15]}}, opnd_q}}; end
            OpLdc, OpLdcW: begin
              if (pk == PkStr) begin do_push = 1'b1; pv = {VkStr, pool_r[31:0]}; end
              else if (pk == PkInt) begin do_push = 1'b1; pv = {VkInt, pool_r[31:0]}; end
              else sk = ErrConst;
            end
            OpDup: begin
              if (dep_q == '0) sk = ErrStack;
              else begin do_push = 1'b1; pv = top_r; end
            end
            OpIadd, OpIsub, OpImul, OpIdiv: begin
              if (dep_q < DepW'(2)) sk = ErrStack;
              else if (op_q == OpIdiv && top_r[31:0] == '0) sk = ErrDivZero;
              else if (op_q == OpIdiv) begin
                div_start = 1'b1; st_d = StDiv;
              end else begin
                stk_we = 1'b1; stk_wa = SpW'(dep_q - DepW'(2));
                dep_d = dep_q - DepW'(1);
                if (op_q == OpIadd) stk_wd = {sec_r[33:32], sec_r[31:0] + top_r[31:0]};
                else if (op_q == OpIsub) stk_wd = {sec_r[33:32], sec_r[31:0] - top_r[31:0]};
                else stk_wd = {sec_r[33:32], mul_p};
              end
            end
            OpIneg: begin
              if (dep_q == '0) sk = ErrStack;
              else begin
                stk_we = 1'b1; stk_wa = SpW'(dep_q - DepW'(1));
                stk_wd = {top_r[33:32], 32'd0 - top_r[31:0]};
              end
            end
            OpGetstatic: begin
              if (pk != PkStdout) sk = ErrGetstatic;
              else begin do_push = 1'b1; pv = {VkStream, 32'd0}; end
            end
            OpInvoke: begin
              if (dep_q < DepW'(2)) sk = ErrStack;
              else begin
                dep_d = dep_q - DepW'(2);
                if (pk < PkPrintlnStr || pk > PkMethod || sec_r[33:32] != VkStream)
                  sk = ErrInvoke;
                else if (pk == PkMethod) sk = ErrMethod;
                else if ((pk == PkPrintlnStr || pk == PkPrintStr) && top_r[33:32] == VkStr) begin
                  res_d.ev = EvPstr; res_d.nl = (pk == PkPrintlnStr); res_d.val = top_r[31:0];
                end else if ((pk == PkPrintlnInt || pk == PkPrintInt) &&
                             top_r[33:32] == VkInt) begin
                  res_d.ev = EvPint; res_d.nl = (pk == PkPrintlnInt); res_d.val = top_r[31:0];
                end else sk = ErrSig;
              end
            end
            OpReturn: begin res_d.ev = EvDone; stop_d = 1'b1; end
            default: sk = ErrOpcode;
          endcase
        end
        if (do_push) begin
          if (dep_q + DepW'(1) >= DepW'(StackDepth)) sk = ErrStack;
          else begin
            stk_we = 1'b1; stk_wa = dep_q[SpW-1:0]; stk_wd = pv;
            dep_d = dep_q + DepW'(1);
          end
        end
        if (sk != ErrNone) begin
          res_d.ev = EvErr; res_d.err = sk; stop_d = 1'b1;
        end
      end
      StDiv: begin
        if (div_done) begin
          stk_we = 1'b1; stk_wa = SpW'(dep_q - DepW'(2));
          stk_wd = {sec_r[33:32], div_q};
          dep_d = dep_q - DepW'(1);
          st_d = StOut;
        end
      end
      StOut: if (m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr;
      dep_q <= '0;
      stop_q <= 1'b0;
      cnt_q <= '0;
      clr_q <= '0;
    end else begin
      st_q <= st_d;
      dep_q <= dep_d;
      stop_q <= stop_d;
      if (cfg_we_i) cnt_q <= cfg_wdata_i;
      if (st_q == StClr) clr_q <= clr_q + (LocW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (acc) begin
      op_q <= in_op;
      opnd_q <= in_opnd;
    end
  end

  `SBX_ASSERT_IMPL(a_depth_bound, 1'b1, dep_q < DepW'(StackDepth))
  `SBX_ASSERT_NEXT(a_halt_sticky, stop_q, stop_q)
  `SBX_ASSERT_IMPL(a_no_accept_busy, st_q != StIdle, !acc)
  `SBX_ASSERT_NEXT(a_err_halts, m_axis_tvalid && (res_q.ev == EvErr || res_q.ev == EvDone), stop_q)
endmodule
`default_nettype wire

@@ design/sbx_div.sv @@
`default_nettype none
// iterative signed divider, one quotient bit per cycle, truncating
// done is a registered flag that rises together with the final quotient after the last step
module sbx_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic        neg_q, neg_d;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dsr_d = dsr_q;
    neg_d = neg_q;
    shifted = {rem_q[30:0], quo_q[31]};
    trial = {1'b0, shifted} - {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = 6'd0;
      rem_d = '0;
      quo_d = dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      dsr_d = divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      neg_d = dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      if (trial[32]) begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (32'd0 - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      done_q <= busy_q && !start_i && (cnt_q == 6'd31);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbx_pkg::*;

  localparam bit FuncLoad = 1'b0;
  localparam bit FuncExec = 1'b1;
  localparam logic [3:0] PkBadKind  = 4'd15;
  // fixed pool layout used by the programs
  localparam int SlotStdout = 1;
  localparam int SlotLnStr = 2;
  localparam int SlotLnInt = 3;
  localparam int SlotLnAny = 4;
  localparam int SlotPrStr = 5;
  localparam int SlotPrInt = 6;
  localparam int SlotPrAny = 7;
  localparam int SlotMethod = 8;
  localparam int SlotUnusable = 9;
  localparam int SlotBadKind = 10;
  localparam int SlotDataLo = 11;
  localparam int SlotDataHi = 40;
  localparam int SlotWideInt = 700;
  localparam int SlotTopStr = 1023;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic        func;
    logic [7:0]  op;
    logic [15:0] opnd;
    logic [9:0]  eidx;
    logic [3:0]  ekind;
    logic [31:0] evalue;
  } instr_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  // shadow state of the execution unit
  logic [33:0] opstack_m [StackDepth];
  int unsigned depth_m;
  logic [33:0] locals_m [LocalCount];
  logic [35:0] pool_m [PoolDepth];
  bit          pool_loaded [PoolDepth];
  bit          halted_m;
  int unsigned pool_count_m;

  result_t pending_events[$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned prints_seen = 0;
  int unsigned cycles = 0;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  bit rx_hold = 1'b0;
  logic [3:0] last_err = ErrNone;

  stack_bytecode_execution_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[stack_bytecode_execution_unit] ERROR");
      $finish;
    end
  end

  function automatic result_t mk_event(logic [2:0] ev, logic nl, logic [31:0] val,
                                       logic [3:0] err);
    result_t r;
    r.ev = ev;
    r.nl = nl;
    r.val = val;
    r.err = err;
    return r;
  endfunction

  function automatic result_t trap(logic [3:0] code);
    halted_m = 1'b1;
    return mk_event(EvErr, 1'b0, '0, code);
  endfunction

  function automatic result_t push_entry(logic [33:0] e);
    if (depth_m + 1 >= StackDepth) return trap(ErrStack);
    opstack_m[depth_m] = e;
    depth_m++;
    return mk_event(EvNone, 1'b0, '0, ErrNone);
  endfunction

  // kind of a pool slot, zero when the index is not in use
  function automatic logic [3:0] pool_kind(int unsigned idx, output logic [31:0] v);
    v = '0;
    if (idx == 0 || idx >= pool_count_m || idx >= PoolDepth) return PkUnusable;
    v = pool_m[idx][31:0];
    return pool_m[idx][35:32];
  endfunction

  function automatic result_t execute_instr(instr_t it);
    logic [7:0] lo8;
    logic [31:0] a, b, v;
    logic [33:0] e, arg, recv;
    logic [3:0] k;
    int unsigned idx;
    bit line;
    lo8 = it.opnd[7:0];
    if (it.func == FuncLoad) begin
      pool_m[it.eidx] = {it.ekind, it.evalue};
      pool_loaded[it.eidx] = 1'b1;
      return mk_event(EvNone, 1'b0, '0, ErrNone);
    end
    if (halted_m) return mk_event(EvHalted, 1'b0, '0, ErrNone);
    if (it.op >= OpIconstM1 && it.op <= OpIconst5)
      return push_entry({VkInt, 32'(it.op) - 32'd3});
    if ((it.op >= OpIload0 && it.op <= OpIload3) || it.op == OpIload) begin
      idx = (it.op == OpIload) ? lo8 : it.op - OpIload0;
      return push_entry(locals_m[idx]);
    end
    if ((it.op >= OpIstore0 && it.op <= OpIstore3) || it.op == OpIstore) begin
      idx = (it.op == OpIstore) ? lo8 : it.op - OpIstore0;
      if (depth_m < 1) return trap(ErrStack);
      depth_m--;
      locals_m[idx] = opstack_m[depth_m];
      return mk_event(EvNone, 1'b0, '0, ErrNone);
    end
    case (it.op)
      OpBipush: return push_entry({VkInt, {{24{lo8[7]}}, lo8}});
      OpSipush: return push_entry({VkInt, {{16{it.opnd[15]}}, it.opnd}});
      OpLdc, OpLdcW: begin
        k = pool_kind((it.op == OpLdc) ? lo8 : it.opnd, v);
        if (k == PkStr) return push_entry({VkStr, v});
        if (k == PkInt) return push_entry({VkInt, v});
        return trap(ErrConst);
      end
      OpDup: begin
        if (depth_m < 1) return trap(ErrStack);
        return push_entry(opstack_m[depth_m - 1]);
      end
      OpIadd, OpIsub, OpImul, OpIdiv: begin
        if (depth_m < 2) return trap(ErrStack);
        e = opstack_m[depth_m - 2];
        a = e[31:0];
        b = opstack_m[depth_m - 1][31:0];
        if (it.op == OpIdiv && b == 0) return trap(ErrDivZero);
        case (it.op)
          OpIadd: a = a + b;
          OpIsub: a = a - b;
          OpImul: a = a * b;
          default: begin
            // most negative over minus one keeps the dividend
            if (!(a == 32'h8000_0000 && b == 32'hffff_ffff)) a = $signed(a) / $signed(b);
          end
        endcase
        opstack_m[depth_m - 2] = {e[33:32], a};
        depth_m--;
        return mk_event(EvNone, 1'b0, '0, ErrNone);
      end
      OpIneg: begin
        if (depth_m < 1) return trap(ErrStack);
        e = opstack_m[depth_m - 1];
        opstack_m[depth_m - 1] = {e[33:32], 32'd0 - e[31:0]};
        return mk_event(EvNone, 1'b0, '0, ErrNone);
      end
      OpGetstatic: begin
        if (pool_kind(it.opnd, v) != PkStdout) return trap(ErrGetstatic);
        return push_entry({VkStream, 32'd0});
      end
      OpInvoke: begin
        if (depth_m < 2) return trap(ErrStack);
        arg = opstack_m[depth_m - 1];
        recv = opstack_m[depth_m - 2];
        depth_m -= 2;
        k = pool_kind(it.opnd, v);
        if (k < PkPrintlnStr || k > PkMethod || recv[33:32] != VkStream)
          return trap(ErrInvoke);
        if (k == PkMethod) return trap(ErrMethod);
        line = (k <= PkPrintlnAny);
        if ((k == PkPrintlnStr || k == PkPrintStr) && arg[33:32] == VkStr)
          return mk_event(EvPstr, line, arg[31:0], ErrNone);
        if ((k == PkPrintlnInt || k == PkPrintInt) && arg[33:32] == VkInt)
          return mk_event(EvPint, line, arg[31:0], ErrNone);
        return trap(ErrSig);
      end
      OpReturn: begin
        halted_m = 1'b1;
        return mk_event(EvDone, 1'b0, '0, ErrNone);
      end
      default: return trap(ErrOpcode);
    endcase
  endfunction

  function automatic bit slot_is(int unsigned idx, logic [3:0] k1, logic [3:0] k2);
    if (idx == 0 || idx >= pool_count_m || idx >= PoolDepth || !pool_loaded[idx])
      return 1'b0;
    return pool_m[idx][35:32] == k1 || pool_m[idx][35:32] == k2;
  endfunction

  function automatic instr_t exec_instr(logic [7:0] op, logic [15:0] opnd);
    instr_t it;
    it.func = FuncExec;
    it.op = op;
    it.opnd = opnd;
    // load fields are don't-care on execute beats
    it.eidx = 10'($urandom);
    it.ekind = 4'($urandom);
    it.evalue = $urandom;
    return it;
  endfunction

  function automatic instr_t load_instr(int unsigned idx, logic [3:0] k, logic [31:0] v);
    instr_t it;
    it.func = FuncLoad;
    it.op = 8'($urandom);
    it.opnd = 16'($urandom);
    it.eidx = 10'(idx);
    it.ekind = k;
    it.evalue = v;
    return it;
  endfunction

  function automatic bit is_known_op(logic [7:0] op);
    if (op >= OpIconstM1 && op <= OpIconst5) return 1'b1;
    if (op >= OpIload0 && op <= OpIload3) return 1'b1;
    if (op >= OpIstore0 && op <= OpIstore3) return 1'b1;
    case (op)
      OpBipush, OpSipush, OpLdc, OpLdcW, OpIload, OpIstore, OpDup, OpIadd, OpIsub,
      OpImul, OpIdiv, OpIneg, OpGetstatic, OpInvoke, OpReturn: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // picks an instruction that keeps the program running
  function automatic instr_t pick_safe_instr();
    int unsigned c, idx;
    bit room;
    logic [7:0] op;
    logic [15:0] junk;
    forever begin
      c = $urandom_range(0, 89);
      room = depth_m < 200;
      junk = 16'($urandom);
      if (c < 15) begin
        if (room) return exec_instr(OpIconstM1 + 8'($urandom_range(0, 6)), junk);
      end else if (c < 25) begin
        if (room) return exec_instr(OpBipush, junk);
      end else if (c < 32) begin
        if (room) return exec_instr(OpSipush, junk);
      end else if (c < 40) begin
        idx = $urandom_range(SlotDataLo, SlotDataHi);
        if (room && slot_is(idx, PkInt, PkStr))
          return exec_instr(OpLdc, {junk[15:8], 8'(idx)});
      end else if (c < 46) begin
        case ($urandom_range(0, 2))
          0: idx = SlotWideInt;
          1: idx = SlotTopStr;
          default: idx = $urandom_range(SlotDataLo, SlotDataHi);
        endcase
        if (room && slot_is(idx, PkInt, PkStr)) return exec_instr(OpLdcW, 16'(idx));
      end else if (c < 54) begin
        op = $urandom_range(0, 1) ? OpIload : OpIload0 + 8'($urandom_range(0, 3));
        if (room) return exec_instr(op, junk);
      end else if (c < 62) begin
        op = $urandom_range(0, 1) ? OpIstore : OpIstore0 + 8'($urandom_range(0, 3));
        if (depth_m >= 1) return exec_instr(op, junk);
      end else if (c < 67) begin
        if (room && depth_m >= 1) return exec_instr(OpDup, junk);
      end else if (c < 85) begin
        case ($urandom_range(0, 3))
          0: op = OpIadd;
          1: op = OpIsub;
          2: op = OpImul;
          default: op = OpIdiv;
        endcase
        if (depth_m >= 2 && !(op == OpIdiv && opstack_m[depth_m - 1][31:0] == 0))
          return exec_instr(op, junk);
      end else begin
        if (depth_m >= 1) return exec_instr(OpIneg, junk);
      end
    end
  endfunction

  task automatic send_instr(input instr_t it);
    int unsigned gap;
    bit took;
    pending_events.push_back(execute_instr(it));
    beats_sent++;
    gap = quiet_tx ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.func;
    s_axis_tdata <= {2'd0, it.evalue, it.ekind, it.eidx, it.opnd, it.op};
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pool_count(input int unsigned count);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 11'(count);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_count_m = count;
  endtask

  // getstatic, an argument, then a matching print call
  task automatic send_print();
    int unsigned idx, slot;
    bit as_str;
    as_str = 1'b0;
    idx = 0;
    if (!slot_is(SlotStdout, PkStdout, PkStdout) || depth_m >= 200) return;
    if ($urandom_range(0, 1)) begin
      repeat (8) begin
        idx = $urandom_range(SlotDataLo, SlotDataHi);
        if (slot_is(idx, PkStr, PkStr)) as_str = 1'b1;
        if (as_str) break;
      end
    end
    if (as_str) slot = $urandom_range(0, 1) ? SlotLnStr : SlotPrStr;
    else slot = $urandom_range(0, 1) ? SlotLnInt : SlotPrInt;
    send_instr(exec_instr(OpGetstatic, 16'(SlotStdout)));
    if (as_str) send_instr(exec_instr(OpLdc, 16'(idx)));
    else send_instr(exec_instr(OpSipush, 16'($urandom)));
    send_instr(exec_instr(OpInvoke, 16'(slot)));
  endtask

  task automatic test_pool_load();
    int unsigned i;
    send_instr(load_instr(SlotStdout, PkStdout, $urandom));
    send_instr(load_instr(SlotLnStr, PkPrintlnStr, $urandom));
    send_instr(load_instr(SlotLnInt, PkPrintlnInt, $urandom));
    send_instr(load_instr(SlotLnAny, PkPrintlnAny, $urandom));
    send_instr(load_instr(SlotPrStr, PkPrintStr, $urandom));
    send_instr(load_instr(SlotPrInt, PkPrintInt, $urandom));
    send_instr(load_instr(SlotPrAny, PkPrintAny, $urandom));
    send_instr(load_instr(SlotMethod, PkMethod, $urandom));
    send_instr(load_instr(SlotUnusable, PkUnusable, $urandom));
    send_instr(load_instr(SlotBadKind, PkBadKind, $urandom));
    send_instr(load_instr(SlotWideInt, PkInt, 32'h7fff_ffff));
    send_instr(load_instr(SlotTopStr, PkStr, 32'h8000_0000));
    for (i = SlotDataLo; i <= SlotDataHi; i++)
      send_instr(load_instr(i, $urandom_range(0, 1) ? PkInt : PkStr, $urandom));
    // no pool slot in use yet, plain pushes still run
    send_instr(exec_instr(OpIconstM1, 16'hffff));
    send_instr(exec_instr(OpIconst5, 16'h0000));
  endtask

  task automatic test_directed_ops();
    send_instr(exec_instr(OpBipush, 16'h0080));
    send_instr(exec_instr(OpBipush, 16'hff7f));
    send_instr(exec_instr(OpSipush, 16'h8000));
    send_instr(exec_instr(OpSipush, 16'h7fff));
    send_instr(exec_instr(OpIadd, 16'h0));
    send_instr(exec_instr(OpImul, 16'h0));
    send_instr(exec_instr(OpLdc, 16'(SlotDataLo)));
    send_instr(exec_instr(OpIsub, 16'h0));
    // most negative value divided by minus one
    send_instr(exec_instr(OpLdcW, 16'(SlotWideInt)));
    send_instr(exec_instr(OpIconstM1 + 8'd2, 16'h0));
    send_instr(exec_instr(OpIadd, 16'h0));
    send_instr(exec_instr(OpIconstM1, 16'h0));
    send_instr(exec_instr(OpIdiv, 16'h0));
    send_instr(exec_instr(OpIneg, 16'h0));
    send_instr(exec_instr(OpDup, 16'h0));
    send_instr(exec_instr(OpIstore, 16'h00ff));
    send_instr(exec_instr(OpIload, 16'hffff));
    send_instr(exec_instr(OpIstore0 + 8'd3, 16'h0));
    send_instr(exec_instr(OpIload0 + 8'd1, 16'h0));
    send_instr(exec_instr(OpGetstatic, 16'(SlotStdout)));
    send_instr(exec_instr(OpBipush, 16'h00fb));
    send_instr(exec_instr(OpInvoke, 16'(SlotLnInt)));
    send_instr(exec_instr(OpGetstatic, 16'(SlotStdout)));
    send_instr(exec_instr(OpLdcW, 16'(SlotTopStr)));
    send_instr(exec_instr(OpInvoke, 16'(SlotPrStr)));
  endtask

  task automatic test_random_program(input int unsigned n);
    int unsigned i, r;
    for (i = 0; i < n; i++) begin
      if (i % 48 == 0) begin
        quiet_tx = ($urandom_range(0, 3) == 0);
        quiet_rx = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 5)
        send_instr(load_instr($urandom_range(SlotDataLo, SlotDataHi),
                              $urandom_range(0, 1) ? PkInt : PkStr, $urandom));
      else if (r < 9)
        send_instr(load_instr($urandom_range(SlotDataHi + 1, SlotWideInt - 1),
                              4'($urandom), $urandom));
      else if (r < 20)
        send_print();
      else
        send_instr(pick_safe_instr());
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  task automatic test_backpressure();
    int unsigned i;
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    quiet_tx = 1'b1;
    for (i = 0; i < 30; i++) send_instr(pick_safe_instr());
    quiet_tx = 1'b0;
    drain_results();
  endtask

  // the unit stops for good after one fault, so each run ends on one kind
  task automatic test_fault();
    logic [7:0] op;
    case ($urandom_range(0, 9))
      0: begin
        do op = 8'($urandom); while (is_known_op(op));
        send_instr(exec_instr(op, 16'($urandom)));
      end
      1: send_instr(exec_instr(OpLdc, 16'($urandom_range(0, 1) ? SlotUnusable : SlotBadKind)));
      2: begin
        send_instr(exec_instr(OpIconstM1 + 8'd2, 16'h0));
        send_instr(exec_instr(OpIconstM1 + 8'd1, 16'h0));
        send_instr(exec_instr(OpIdiv, 16'h0));
      end
      3: send_instr(exec_instr(OpGetstatic, 16'($urandom_range(0, 1) ? SlotLnInt : 0)));
      4: begin
        send_instr(exec_instr(OpBipush, 16'h0001));
        send_instr(exec_instr(OpBipush, 16'h0002));
        send_instr(exec_instr(OpInvoke, 16'(SlotLnInt)));
      end
      5: begin
        send_instr(exec_instr(OpGetstatic, 16'(SlotStdout)));
        send_instr(exec_instr(OpBipush, 16'h0003));
        send_instr(exec_instr(OpInvoke, 16'($urandom_range(0, 1) ? SlotLnStr : SlotPrAny)));
      end
      6: begin
        send_instr(exec_instr(OpGetstatic, 16'(SlotStdout)));
        send_instr(exec_instr(OpBipush, 16'h0004));
        send_instr(exec_instr(OpInvoke, 16'(SlotMethod)));
      end
      7: begin
        while (depth_m > 0) send_instr(exec_instr(OpIstore0, 16'h0));
        send_instr(exec_instr(OpIadd, 16'h0));
      end
      8: while (!halted_m) send_instr(exec_instr(OpIconstM1 + 8'd1, 16'h0));
      default: send_instr(exec_instr(OpReturn, 16'($urandom)));
    endcase
  endtask

  task automatic test_halted();
    int unsigned i;
    instr_t it;
    for (i = 0; i < 30; i++) begin
      it = exec_instr(8'($urandom), 16'($urandom));
      it.func = $urandom_range(0, 1);
      send_instr(it);
    end
  endtask

  // receiving side: random stalls, result check against the oldest prediction
  initial begin : rx_side
    int unsigned stall;
    bit got;
    logic [39:0] beat;
    result_t want, seen;
    @(posedge rst_ni);
    forever begin
      stall = quiet_rx ? 0 : $urandom_range(0, 18);
      if (stall > 0 || rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (rx_hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        got = m_axis_tvalid;
        beat = m_axis_tdata;
        @(posedge clk_i);
      end while (!got);
      beats_seen++;
      seen = mk_event(beat[2:0], beat[3], beat[35:4], beat[39:36]);
      if (seen.ev == EvPint || seen.ev == EvPstr) prints_seen++;
      if (seen.ev == EvErr) last_err = seen.err;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat ev=%0d err=%0d", seen.ev, seen.err);
      end else begin
        want = pending_events.pop_front();
        if (seen != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: expected ev=%0d nl=%0d val=%h err=%0d, got ev=%0d nl=%0d val=%h err=%0d",
                     beats_seen, want.ev, want.nl, want.val, want.err,
                     seen.ev, seen.nl, seen.val, seen.err);
        end
      end
    end
  end

  initial begin
    int unsigned i;
    depth_m = 0;
    halted_m = 1'b0;
    pool_count_m = 0;
    for (i = 0; i < LocalCount; i++) locals_m[i] = '0;
    for (i = 0; i < PoolDepth; i++) begin
      pool_m[i] = '0;
      pool_loaded[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pool_load();
    write_pool_count(1024);
    test_directed_ops();
    test_random_program(380);
    test_backpressure();
    write_pool_count(SlotDataHi + 1);
    test_random_program(280);
    write_pool_count(1);
    test_random_program(120);
    write_pool_count(0);
    test_random_program(80);
    write_pool_count(777);
    test_random_program(280);
    drain_results();
    test_fault();
    test_halted();

    drain_results();
    repeat (60) @(posedge clk_i);
    $display("sent %0d beats, checked %0d results, %0d of them prints",
             beats_sent, beats_seen, prints_seen);
    $display("program ended with error code %0d, %0d mismatches", last_err, mismatches);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("[stack_bytecode_execution_unit] OK");
    end else begin
      $display("[stack_bytecode_execution_unit] ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+design
design/sbx_pkg.sv
design/sbx_div.sv
design/stack_bytecode_execution_unit.sv
tb/sv/tb_top.sv
